// ----- sv/cvp_pkg.sv -----
// Shared types, status codes and the colour name table of the CSS colour value parser.
package cvp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic [31:0] color;
        logic [1:0]  status;
        logic [15:0] consumed;
    } result_item_t;

    // One classified byte as it travels from the front end to the parser.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_alnum;
        logic       is_digit;
        logic       is_space;
        logic       is_hash;
        logic       is_lparen;
        logic       is_rparen;
        logic       is_comma;
        logic       is_hex;
        logic [3:0] nibble;
    } byte_class_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [7:0] ALPHA_FF = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    localparam int NAME_COUNT = 16;
    localparam int NAME_MAX   = 7;
    localparam int TEXT_W     = NAME_MAX * 8;

    // Names are left aligned: character k sits at bits [TEXT_W-1-8k -: 8].
    localparam logic [TEXT_W-1:0] NAME_TEXT [NAME_COUNT] = '{
        {"black", 16'd0}, {"silver", 8'd0}, {"gray", 24'd0},  {"white", 16'd0},
        {"maroon", 8'd0}, {"red", 32'd0},   {"purple", 8'd0}, "fuchsia",
        {"green", 16'd0}, {"lime", 24'd0},  {"olive", 16'd0}, {"yellow", 8'd0},
        {"navy", 24'd0},  {"blue", 24'd0},  {"teal", 24'd0},  {"aqua", 24'd0}
    };

    localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
        3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd3, 3'd6, 3'd7,
        3'd5, 3'd4, 3'd5, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam logic [31:0] NAME_RGBA [NAME_COUNT] = '{
        32'h000000FF, 32'hC0C0C0FF, 32'h808080FF, 32'hFFFFFFFF,
        32'h800000FF, 32'hFF0000FF, 32'h800080FF, 32'hFF00FFFF,
        32'h008000FF, 32'h00FF00FF, 32'h808000FF, 32'hFFFF00FF,
        32'h000080FF, 32'h0000FFFF, 32'h008080FF, 32'h00FFFFFF
    };

    localparam logic [TEXT_W-1:0] RGB_TEXT = {"rgb", 32'd0};
    localparam logic [2:0]        RGB_LEN  = 3'd3;

endpackage

// ----- sv/cvp_front.sv -----
// Front end: takes text bytes and classifies each one for the parser.
module cvp_front (
    input  logic                   text_valid,
    output logic                   text_ready,
    input  cvp_pkg::text_item_t    text_item,
    input  logic                   queue_space,
    output logic                   push,
    output cvp_pkg::byte_class_t   cls
);

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    logic [7:0] c;
    logic       dig;
    logic       up;
    logic       low;
    logic       up_hex;
    logic       low_hex;

    assign c       = text_item.ch;
    assign dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    assign up      = (c >= CH_UA) && (c <= CH_UZ);
    assign low     = (c >= CH_LA) && (c <= CH_LZ);
    assign up_hex  = (c >= CH_UA) && (c <= CH_UF);
    assign low_hex = (c >= CH_LA) && (c <= CH_LF);

    assign text_ready = queue_space;
    assign push       = text_valid && queue_space;

    always_comb
    begin
        cls.ch        = c;
        cls.last      = text_item.last;
        cls.is_alnum  = dig || up || low;
        cls.is_digit  = dig;
        cls.is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        cls.is_hash   = (c == CH_HASH);
        cls.is_lparen = (c == CH_LPAREN);
        cls.is_rparen = (c == CH_RPAREN);
        cls.is_comma  = (c == CH_COMMA);
        cls.is_hex    = dig || up_hex || low_hex;
        // letters a..f and A..F share their low nibble: 1..6
        if (dig)
        begin
            cls.nibble = c[3:0];
        end
        else
        begin
            cls.nibble = 4'(c[2:0] + 4'd9);
        end
    end

endmodule

// ----- sv/cvp_queue.sv -----
// Short queue of classified bytes between the front end and the parser.
module cvp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cvp_pkg::byte_class_t   push_data,
    output logic                   space,
    input  logic                   pop,
    output logic                   head_valid,
    output cvp_pkg::byte_class_t   head
);

    localparam int DEPTH = cvp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cvp_pkg::byte_class_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign space      = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/cvp_back.sv -----
// Parser back end: parses one classified byte a cycle unless stalled; registers results.
module cvp_back #(
    parameter int NAME_CHARS = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  cvp_pkg::byte_class_t   head,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output cvp_pkg::result_item_t  result_item
);

    localparam int LEN_W  = $clog2(NAME_CHARS + 2);
    localparam int IDX_W  = $clog2(NAME_CHARS);
    localparam int TEXT_W = cvp_pkg::TEXT_W;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WORD,
        PH_HEX,
        PH_HEX_BAD,
        PH_PAREN,
        PH_LEAD,
        PH_NUM,
        PH_SEP,
        PH_DRAIN
    } phase_t;

    typedef logic [NAME_CHARS-1:0][7:0] word_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    word_t                 chars_reg;
    word_t                 chars_next;
    logic [LEN_W-1:0]      wlen_reg;
    logic [LEN_W-1:0]      wlen_next;
    logic [31:0]           acc_reg;
    logic [31:0]           acc_next;
    logic [7:0]            cb_reg;
    logic [7:0]            cb_next;
    logic [1:0]            ci_reg;
    logic [1:0]            ci_next;
    logic [15:0]           cnt_reg;
    logic [15:0]           cnt_next;
    logic                  result_valid_reg;
    cvp_pkg::result_item_t result_reg;

    // rgb sub-parser outputs
    phase_t                rgb_in_ph;
    phase_t                r_ph;
    logic [31:0]           r_acc;
    logic [31:0]           acc_fin;
    logic [7:0]            r_cb;
    logic [1:0]            r_ci;
    logic [15:0]           r_cnt;
    logic                  r_emit;
    cvp_pkg::result_item_t r_item;
    logic                  finish;
    logic                  do_sep;

    logic                  emit;
    cvp_pkg::result_item_t e_item;
    logic                  word_end;
    logic                  name_end;
    logic [32:0]           lookup;
    logic [15:0]           cnt_inc;
    logic [3:0]            hex_v;
    logic [1:0]            hex_ci;

    function automatic logic word_is(input word_t w, input logic [LEN_W-1:0] wl,
                                     input logic [TEXT_W-1:0] text, input logic [2:0] tl);
        logic hit;
        hit = (wl == LEN_W'(tl));
        for (int k = 0; k < cvp_pkg::NAME_MAX; k++)
        begin
            if ((k < int'(tl)) && (w[k] != text[TEXT_W-1-8*k -: 8]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // {hit, rgba}; names are distinct so at most one entry hits
    function automatic logic [32:0] name_lookup(input word_t w, input logic [LEN_W-1:0] wl);
        logic [32:0] res;
        res = '0;
        for (int i = 0; i < cvp_pkg::NAME_COUNT; i++)
        begin
            if (word_is(w, wl, cvp_pkg::NAME_TEXT[i], cvp_pkg::NAME_LEN[i]))
            begin
                res = res | {1'b1, cvp_pkg::NAME_RGBA[i]};
            end
        end
        return res;
    endfunction

    assign pop          = head_valid && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;
    assign cnt_inc      = (cnt_reg == 16'hFFFF) ? cnt_reg : 16'(cnt_reg + 1'b1);

    // rgb( ... ) grammar; a word phase hands over to it as if at the parenthesis
    always_comb
    begin
        rgb_in_ph = (phase_reg == PH_WORD) ? PH_PAREN : phase_reg;
        r_ph      = rgb_in_ph;
        r_acc     = acc_reg;
        r_cb      = cb_reg;
        r_ci      = ci_reg;
        r_cnt     = cnt_reg;
        r_emit    = 1'b0;
        r_item    = '0;
        finish    = 1'b0;
        do_sep    = 1'b0;
        acc_fin   = {acc_reg[23:0], cb_reg};
        unique case (rgb_in_ph)
            PH_PAREN:
            begin
                if (head.is_space)
                begin
                    r_cnt = cnt_inc;
                end
                else if (head.is_lparen)
                begin
                    r_cnt = cnt_inc;
                    r_ph  = PH_LEAD;
                    r_ci  = '0;
                    r_cb  = '0;
                    r_acc = '0;
                end
                else
                begin
                    r_emit        = 1'b1;
                    r_item.status = cvp_pkg::ST_SYNTAX;
                end
            end
            PH_LEAD:
            begin
                if (head.is_space)
                begin
                    r_cnt = cnt_inc;
                end
                else if (head.is_digit)
                begin
                    r_cnt = cnt_inc;
                    r_cb  = {4'd0, head.nibble};
                    r_ph  = PH_NUM;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_NUM:
            begin
                if (head.is_digit)
                begin
                    r_cnt = cnt_inc;
                    r_cb  = 8'({cb_reg, 3'b000} + {2'b00, cb_reg, 1'b0} + 11'(head.nibble));
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                do_sep = 1'b1;
            end
        endcase

        if (finish)
        begin
            r_acc = acc_fin;
            if (ci_reg < 2'd2)
            begin
                r_ph   = PH_SEP;
                do_sep = 1'b1;
            end
            else if (head.is_rparen)
            begin
                r_cnt           = cnt_inc;
                r_emit          = 1'b1;
                r_item.color    = {acc_fin[23:0], cvp_pkg::ALPHA_FF};
                r_item.status   = cvp_pkg::ST_OK;
                r_item.consumed = cnt_inc;
            end
            else
            begin
                r_emit        = 1'b1;
                r_item.status = cvp_pkg::ST_SYNTAX;
            end
        end

        if (do_sep)
        begin
            if (head.is_space)
            begin
                r_cnt = cnt_inc;
            end
            else if (head.is_comma)
            begin
                r_cnt = cnt_inc;
                r_ci  = 2'(ci_reg + 1'b1);
                r_cb  = '0;
                r_ph  = PH_LEAD;
            end
            else
            begin
                r_emit        = 1'b1;
                r_item        = '0;
                r_item.status = cvp_pkg::ST_SYNTAX;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        chars_next = chars_reg;
        wlen_next  = wlen_reg;
        acc_next   = acc_reg;
        cb_next    = cb_reg;
        ci_next    = ci_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        e_item     = '0;
        word_end   = 1'b0;
        name_end   = 1'b0;
        lookup     = '0;
        hex_v      = head.is_hex ? head.nibble : 4'd0;
        hex_ci     = 2'(ci_reg + 1'b1);

        unique case (phase_reg)
            PH_IDLE:
            begin
                wlen_next = '0;
                cnt_next  = '0;
                acc_next  = '0;
                cb_next   = '0;
                ci_next   = '0;
                if (head.is_alnum)
                begin
                    chars_next[0] = head.ch;
                    wlen_next     = LEN_W'(1);
                    cnt_next      = 16'd1;
                    phase_next    = PH_WORD;
                    word_end      = head.last;
                end
                else if (head.is_hash)
                begin
                    cnt_next   = 16'd1;
                    phase_next = PH_HEX;
                    if (head.last)
                    begin
                        emit          = 1'b1;
                        e_item.status = cvp_pkg::ST_UNKNOWN;
                    end
                end
                else
                begin
                    emit          = 1'b1;
                    e_item.status = cvp_pkg::ST_UNKNOWN;
                end
            end
            PH_WORD:
            begin
                if (head.is_alnum)
                begin
                    if (wlen_reg < LEN_W'(NAME_CHARS))
                    begin
                        chars_next[wlen_reg[IDX_W-1:0]] = head.ch;
                    end
                    if (wlen_reg <= LEN_W'(NAME_CHARS))
                    begin
                        wlen_next = LEN_W'(wlen_reg + 1'b1);
                    end
                    cnt_next = cnt_inc;
                    word_end = head.last;
                end
                else if (word_is(chars_reg, wlen_reg, cvp_pkg::RGB_TEXT, cvp_pkg::RGB_LEN))
                begin
                    phase_next = r_ph;
                    acc_next   = r_acc;
                    cb_next    = r_cb;
                    ci_next    = r_ci;
                    cnt_next   = r_cnt;
                    emit       = r_emit;
                    e_item     = r_item;
                    if (!r_emit && head.last)
                    begin
                        emit          = 1'b1;
                        e_item        = '0;
                        e_item.status = cvp_pkg::ST_SYNTAX;
                    end
                end
                else
                begin
                    name_end = 1'b1;
                end
            end
            PH_HEX, PH_HEX_BAD:
            begin
                if (!head.is_hex)
                begin
                    phase_next = PH_HEX_BAD;
                end
                acc_next = {acc_reg[23:0], hex_v, hex_v};
                ci_next  = hex_ci;
                cnt_next = cnt_inc;
                if (hex_ci == 2'd3)
                begin
                    emit = 1'b1;
                    if ((phase_reg == PH_HEX_BAD) || !head.is_hex)
                    begin
                        e_item.status = cvp_pkg::ST_SYNTAX;
                    end
                    else
                    begin
                        e_item.color    = {acc_reg[15:0], hex_v, hex_v, cvp_pkg::ALPHA_FF};
                        e_item.status   = cvp_pkg::ST_OK;
                        e_item.consumed = cnt_inc;
                    end
                end
                else if (head.last)
                begin
                    emit          = 1'b1;
                    e_item.status = cvp_pkg::ST_UNKNOWN;
                end
            end
            PH_PAREN, PH_LEAD, PH_NUM, PH_SEP:
            begin
                phase_next = r_ph;
                acc_next   = r_acc;
                cb_next    = r_cb;
                ci_next    = r_ci;
                cnt_next   = r_cnt;
                emit       = r_emit;
                e_item     = r_item;
                if (!r_emit && head.last)
                begin
                    emit          = 1'b1;
                    e_item        = '0;
                    e_item.status = cvp_pkg::ST_SYNTAX;
                end
            end
            default:
            begin
                // drain: drop bytes until the end of the text
            end
        endcase

        // a word closed by the end of the text: rgb alone is incomplete
        if (word_end)
        begin
            if (word_is(chars_next, wlen_next, cvp_pkg::RGB_TEXT, cvp_pkg::RGB_LEN))
            begin
                emit          = 1'b1;
                e_item.status = cvp_pkg::ST_SYNTAX;
            end
            else
            begin
                name_end = 1'b1;
            end
        end

        if (name_end)
        begin
            lookup          = name_lookup(chars_next, wlen_next);
            emit            = 1'b1;
            e_item.color    = lookup[32] ? lookup[31:0] : 32'd0;
            e_item.status   = lookup[32] ? cvp_pkg::ST_OK : cvp_pkg::ST_UNKNOWN;
            e_item.consumed = cnt_next;
        end

        if (emit)
        begin
            phase_next = PH_DRAIN;
        end
        if (head.last)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            wlen_reg         <= '0;
            acc_reg          <= '0;
            cb_reg           <= '0;
            ci_reg           <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                wlen_reg  <= wlen_next;
                acc_reg   <= acc_next;
                cb_reg    <= cb_next;
                ci_reg    <= ci_next;
                cnt_reg   <= cnt_next;
            end
            if (pop && emit)
            begin
                result_valid_reg <= 1'b1;
                result_reg       <= e_item;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // word characters hold no reset value; entries past the word length never decide a hit
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            chars_reg <= chars_next;
        end
    end

endmodule

// ----- sv/css_color_value_parser_unit.sv -----
// Top level of the CSS colour value parser: front end, byte queue and parser back end.
//
// Usage: stream the bytes of a CSS colour value on the text channel (text_valid,
// text_ready, text_item), one byte per transaction, with last set on the final byte
// of the text. Accepted forms are rgb(r,g,b), #rgb and the sixteen basic colour
// names. At most one transaction leaves on the result channel (result_valid,
// result_ready, result_item) per value: the colour as RGBA, a status (ok, syntax
// error, unknown word) and the number of bytes consumed. Bytes that follow a
// finished value are dropped until last.
// Throughput: one byte per cycle unless a held result stalls the parser; the parser
// updates its state for one byte per cycle; the name compare runs in that same cycle.
// The byte that completes the value is written into the two-entry byte queue, read
// by the parser from the queue head, and the result is held in the parser's output
// register.
// Stalls: while result_ready is low the held result blocks the parser; the queue
// then fills and text_ready falls once it holds two bytes.
// Reset: rst_n clears the parser to the start of a value and empties the queue
// and the output register; no initialisation pass is needed.
module css_color_value_parser_unit #(
    parameter int NAME_CHARS = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   text_valid,
    output logic                   text_ready,
    input  cvp_pkg::text_item_t    text_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output cvp_pkg::result_item_t  result_item
);

    logic                 queue_space;
    logic                 push;
    logic                 pop;
    logic                 head_valid;
    cvp_pkg::byte_class_t push_data;
    cvp_pkg::byte_class_t head;

    cvp_front u_front (
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .queue_space (queue_space),
        .push        (push),
        .cls         (push_data)
    );

    cvp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .space      (queue_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cvp_back #(
        .NAME_CHARS (NAME_CHARS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.status == cvp_pkg::ST_OK)
                      || (result_item.status == cvp_pkg::ST_SYNTAX)
                      || (result_item.status == cvp_pkg::ST_UNKNOWN))
        else $error("result status outside the defined codes");

    a_fail_black: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.status != cvp_pkg::ST_OK)) |-> (result_item.color == 32'd0))
        else $error("failed value carries a non-zero colour");

    a_syntax_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.status == cvp_pkg::ST_SYNTAX))
            |-> (result_item.consumed == 16'd0))
        else $error("syntax error reports consumed bytes");

    a_ok_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.status == cvp_pkg::ST_OK))
            |-> (result_item.color[7:0] == cvp_pkg::ALPHA_FF) && (result_item.consumed != 16'd0))
        else $error("ok result without opaque alpha or consumed bytes");

    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("parser pops an empty queue");

endmodule

// ----- tb/tb_css_color_value_parser_unit.sv -----
// Self-checking testbench for the CSS colour value parser unit.
module tb_css_color_value_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int WORD_MAX    = 7;
    localparam int SETTLE      = 8;

    typedef enum logic [3:0] {
        AT_START, IN_WORD, IN_HEX, IN_HEX_BAD, WANT_PAREN,
        WANT_NUMBER, IN_NUMBER, WANT_COMMA, SKIP_REST
    } parse_state_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  text_valid = 1'b0;
    logic                  text_ready;
    cvp_pkg::text_item_t   text_item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    cvp_pkg::result_item_t result_item;

    cvp_pkg::text_item_t   text_queue [$];
    cvp_pkg::result_item_t expected_results [$];
    logic [7:0]            build [$];

    int  send_idle = 0;
    int  recv_idle = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  took_byte = 1'b0;

    // Predictor state
    parse_state_t state = AT_START;
    logic [7:0]   word_buf [WORD_MAX];
    logic [3:0]   name_len = '0;
    logic [31:0]  rgba_acc = '0;
    logic [7:0]   comp_val = '0;
    logic [1:0]   comp_idx = '0;
    logic [15:0]  consumed_cnt = '0;
    bit           posted;

    string color_names [16] = '{
        "black", "silver", "gray", "white", "maroon", "red", "purple", "fuchsia",
        "green", "lime", "olive", "yellow", "navy", "blue", "teal", "aqua"
    };
    logic [31:0] color_rgba [16] = '{
        32'h000000FF, 32'hC0C0C0FF, 32'h808080FF, 32'hFFFFFFFF,
        32'h800000FF, 32'hFF0000FF, 32'h800080FF, 32'hFF00FFFF,
        32'h008000FF, 32'h00FF00FF, 32'h808000FF, 32'hFFFF00FF,
        32'h000080FF, 32'h0000FFFF, 32'h008080FF, 32'h00FFFFFF
    };

    css_color_value_parser_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (is_digit(c))
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void bump_consumed();
        if (consumed_cnt != 16'hFFFF)
            consumed_cnt++;
    endfunction

    function automatic void post_result(logic [31:0] c, logic [1:0] s, logic [15:0] n);
        cvp_pkg::result_item_t r;
        r.color    = c;
        r.status   = s;
        r.consumed = n;
        expected_results.push_back(r);
        posted = 1'b1;
        state  = SKIP_REST;
    endfunction

    function automatic bit word_matches(string s);
        if (name_len != s.len())
            return 1'b0;
        for (int k = 0; k < s.len(); k++)
            if (word_buf[k] != s[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void resolve_name();
        for (int i = 0; i < 16; i++)
        begin
            if (word_matches(color_names[i]))
            begin
                post_result(color_rgba[i], cvp_pkg::ST_OK, consumed_cnt);
                return;
            end
        end
        post_result('0, cvp_pkg::ST_UNKNOWN, consumed_cnt);
    endfunction

    // A word cut short by the end of the text: a bare rgb is malformed.
    function automatic void close_word();
        if (word_matches("rgb"))
            post_result('0, cvp_pkg::ST_SYNTAX, '0);
        else
            resolve_name();
    endfunction

    function automatic void comma_byte(logic [7:0] c);
        if (is_space(c))
            bump_consumed();
        else if (c == ",")
        begin
            bump_consumed();
            comp_idx = comp_idx + 2'd1;
            comp_val = '0;
            state    = WANT_NUMBER;
        end
        else
            post_result('0, cvp_pkg::ST_SYNTAX, '0);
    endfunction

    function automatic void close_component(logic [7:0] c);
        rgba_acc = {rgba_acc[23:0], comp_val};
        if (comp_idx < 2'd2)
        begin
            state = WANT_COMMA;
            comma_byte(c);
        end
        else if (c == ")")
        begin
            bump_consumed();
            post_result({rgba_acc[23:0], 8'hFF}, cvp_pkg::ST_OK, consumed_cnt);
        end
        else
            post_result('0, cvp_pkg::ST_SYNTAX, '0);
    endfunction

    function automatic void rgb_step(logic [7:0] c);
        case (state)
            WANT_PAREN:
                if (is_space(c))
                    bump_consumed();
                else if (c == "(")
                begin
                    bump_consumed();
                    state    = WANT_NUMBER;
                    comp_idx = '0;
                    comp_val = '0;
                    rgba_acc = '0;
                end
                else
                    post_result('0, cvp_pkg::ST_SYNTAX, '0);
            WANT_NUMBER:
                if (is_space(c))
                    bump_consumed();
                else if (is_digit(c))
                begin
                    bump_consumed();
                    comp_val = c - "0";
                    state    = IN_NUMBER;
                end
                else
                    close_component(c);
            IN_NUMBER:
                if (is_digit(c))
                begin
                    bump_consumed();
                    comp_val = 8'(comp_val * 8'd10 + (c - "0"));
                end
                else
                    close_component(c);
            default:
                comma_byte(c);
        endcase
    endfunction

    // Advance the predicted parser by one accepted byte.
    function automatic void parse_byte(cvp_pkg::text_item_t it);
        logic [7:0] c;
        int         v;
        c      = it.ch;
        posted = 1'b0;
        case (state)
            AT_START:
            begin
                name_len     = '0;
                consumed_cnt = '0;
                rgba_acc     = '0;
                comp_val     = '0;
                comp_idx     = '0;
                if (is_alnum(c))
                begin
                    word_buf[0] = c;
                    name_len    = 4'd1;
                    bump_consumed();
                    state = IN_WORD;
                    if (it.last)
                        close_word();
                end
                else if (c == "#")
                begin
                    bump_consumed();
                    state = IN_HEX;
                    if (it.last)
                        post_result('0, cvp_pkg::ST_UNKNOWN, '0);
                end
                else
                    post_result('0, cvp_pkg::ST_UNKNOWN, '0);
            end
            IN_WORD:
                if (is_alnum(c))
                begin
                    if (name_len < WORD_MAX)
                        word_buf[name_len[2:0]] = c;
                    if (name_len <= WORD_MAX)
                        name_len++;
                    bump_consumed();
                    if (it.last)
                        close_word();
                end
                else if (word_matches("rgb"))
                begin
                    state = WANT_PAREN;
                    rgb_step(c);
                    if (!posted && it.last)
                        post_result('0, cvp_pkg::ST_SYNTAX, '0);
                end
                else
                    resolve_name();
            IN_HEX, IN_HEX_BAD:
            begin
                v = hex_digit(c);
                if (v < 0)
                begin
                    state = IN_HEX_BAD;
                    v     = 0;
                end
                rgba_acc = {rgba_acc[23:0], 4'(v), 4'(v)};
                comp_idx = comp_idx + 2'd1;
                bump_consumed();
                if (comp_idx == 2'd3)
                begin
                    if (state == IN_HEX_BAD)
                        post_result('0, cvp_pkg::ST_SYNTAX, '0);
                    else
                        post_result({rgba_acc[23:0], 8'hFF}, cvp_pkg::ST_OK, consumed_cnt);
                end
                else if (it.last)
                    post_result('0, cvp_pkg::ST_UNKNOWN, '0);
            end
            WANT_PAREN, WANT_NUMBER, IN_NUMBER, WANT_COMMA:
            begin
                rgb_step(c);
                if (!posted && it.last)
                    post_result('0, cvp_pkg::ST_SYNTAX, '0);
            end
            default:
                ;
        endcase
        if (it.last)
            state = AT_START;
    endfunction

    task automatic check_result(cvp_pkg::result_item_t got);
        cvp_pkg::result_item_t want;
        if (expected_results.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result: color %h status %0d consumed %0d",
                         got.color, got.status, got.consumed);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (want.color !== got.color || want.status !== got.status ||
                want.consumed !== got.consumed)
            begin
                if (mismatches < 10)
                    $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                             want.color, want.status, want.consumed,
                             got.color, got.status, got.consumed);
                mismatches++;
            end
        end
    endtask

    // Sample at the rising edge: check results, then predict from the accepted byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                check_result(result_item);
            took_byte = text_valid && text_ready;
            if (took_byte)
                parse_byte(text_item);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= ($urandom_range(99) >= recv_idle);
            if (!text_valid || took_byte)
            begin
                if (text_queue.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    text_item  <= text_queue.pop_front();
                    text_valid <= 1'b1;
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            build.push_back(s[i]);
    endtask

    task automatic add_byte(logic [7:0] b);
        build.push_back(b);
    endtask

    task automatic commit_value();
        cvp_pkg::text_item_t it;
        for (int i = 0; i < build.size(); i++)
        begin
            it.ch   = build[i];
            it.last = (i == build.size() - 1);
            text_queue.push_back(it);
        end
        build.delete();
    endtask

    task automatic add_blank();
        int n;
        int r;
        n = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(5);
            add_byte(r == 0 ? 8'd32 : 8'(8 + r));
        end
    endtask

    task automatic add_number();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return;
        else if (r < 75)
            add_str($sformatf("%0d", $urandom_range(255)));
        else if (r < 95)
            add_str($sformatf("%0d", $urandom_range(256, 999)));
        else
            add_str($sformatf("%0d", $urandom_range(99999)));
    endtask

    function automatic logic [7:0] pick_non_alnum();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_alnum(b));
        return b;
    endfunction

    task automatic add_random_value(output int core);
        string hex_chars;
        int    kind;
        int    r;
        hex_chars = "0123456789abcdefABCDEF";
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            add_str(color_names[$urandom_range(15)]);
            r = $urandom_range(99);
            if (r < 10)
                build[$urandom_range(build.size() - 1)] ^= 8'h20;
            else if (r < 20)
                add_str("x");
            if ($urandom_range(1))
                add_byte(pick_non_alnum());
        end
        else if (kind < 65)
        begin
            add_str("rgb");
            add_blank();
            add_str("(");
            for (int k = 0; k < 3; k++)
            begin
                add_blank();
                add_number();
                if (k < 2)
                begin
                    add_blank();
                    add_str(",");
                end
            end
            add_str(")");
        end
        else if (kind < 85)
        begin
            add_str("#");
            repeat (3)
            begin
                if ($urandom_range(99) < 90)
                    add_byte(hex_chars[$urandom_range(21)]);
                else
                    add_byte(8'($urandom_range(255)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                add_byte(8'($urandom_range(255)));
        end
        // Break a share of the well-formed values: cut them short or spoil one byte.
        if (kind < 85)
        begin
            r = $urandom_range(99);
            if (r < 10 && build.size() > 1)
                build = build[0:$urandom_range(build.size() - 2)];
            else if (r < 20)
                build[$urandom_range(build.size() - 1)] = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3))
                add_byte(8'($urandom_range(255)));
        core = build.size();
        commit_value();
    endtask

    task automatic add_random_values(int target);
        int total;
        int core;
        total = 0;
        while (total < target)
        begin
            add_random_value(core);
            total += core;
        end
    endtask

    task automatic wait_drained();
        while (text_queue.size() != 0 || text_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_directed();
        add_str("red");             commit_value();
        add_str("fuchsia;");        commit_value();
        add_str("Red ");            commit_value();
        add_str("blacks");          commit_value();
        add_str("abcdefghij");      commit_value();
        add_str("7");               commit_value();
        add_str("rgb(255,0,128)!!"); commit_value();
        add_str("rgb");
        add_byte(8'h0B);
        add_str("( 300 ,\t12 ,");
        add_byte(8'h0C);
        add_byte(8'h0D);
        add_str("\n7)");
        commit_value();
        add_str("rgb(,,)");         commit_value();
        add_str("rgb(1,2,3 )");     commit_value();
        add_str("rgb(1,2");         commit_value();
        add_str("rgb(1;");          commit_value();
        add_str("rgb");             commit_value();
        add_str("rgb(");            commit_value();
        add_str("rgbx(1,2,3)");     commit_value();
        add_str("#fA0");            commit_value();
        add_str("#abcxyz");         commit_value();
        add_str("#F0");             commit_value();
        add_str("#");               commit_value();
        add_str("#g12");            commit_value();
        add_str("%");               commit_value();
        add_byte(8'h00);            commit_value();
        add_byte(8'hFF);            commit_value();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle = 8;
        recv_idle = 87;
        add_directed();
        add_random_values(187);
        wait_drained();

        send_idle = 87;
        recv_idle = 8;
        add_random_values(187);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        add_random_values(186);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
